// ----- hdl/keyed_snapshot_table_mtf_defines.svh -----
// assertion macros for the keyed snapshot table
`ifndef KEYED_SNAPSHOT_TABLE_MTF_DEFINES_SVH
`define KEYED_SNAPSHOT_TABLE_MTF_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define KSTM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define KSTM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define KSTM_ASSERT_SAME(label, ante, cons, msg)
`define KSTM_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ----- hdl/kstm_pkg.sv -----
// shared types and constants for the keyed snapshot table
`timescale 1ns / 1ps

package kstm_pkg;

  localparam int TABLE_DEPTH = 4;
  localparam int SLOT_W      = 2;
  localparam int KEY_W       = 8;
  localparam int MASK_W      = 8;
  localparam int VAL_W       = 16;

  localparam logic [MASK_W-1:0] MASK_VOLT = 8'h01;
  localparam logic [MASK_W-1:0] MASK_CURR = 8'h02;
  localparam logic [MASK_W-1:0] MASK_TEMP = 8'h04;

  typedef enum logic [1:0] {
    CMD_ALLOC  = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_READ   = 2'd2,
    CMD_LOOKUP = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [MASK_W-1:0] mask;
    logic [VAL_W-1:0]  volt;
    logic [VAL_W-1:0]  curr;
    logic [VAL_W-1:0]  temp;
  } record_t;

  typedef struct packed {
    logic              accept;
    cmd_t              cmd;
    logic [KEY_W-1:0]  key;
    logic [MASK_W-1:0] fmask;
    logic [VAL_W-1:0]  wval;
  } cell_ctl_t;

  typedef struct packed {
    logic              sel;
    logic              ok;
    logic [VAL_W-1:0]  rval;
    logic [SLOT_W-1:0] slot;
  } cell_res_t;

endpackage

// ----- hdl/keyed_snapshot_table_mtf.sv -----
// top level of the keyed snapshot table with move-to-front allocation
// usage:
//   input channel in_valid/in_ready carries cmd, key, field_mask and write_value;
//   output channel out_valid/out_ready carries ok, read_value, found and slot.
//   each command is resolved in the cycle it is accepted by a row of record
//   cells that compare the key in parallel and hand records to their neighbor
//   on allocate; the first matching slot wins.
//   output: the result is registered and shows in the cycle after acceptance.
//   throughput: one item per cycle while the output is not stalled, set by the
//   single pass through the cell row and the output register.
//   reset: rst_n low clears every record to zero (all slots empty) and
//   empties the output register.
//   stall: while out_valid is high and out_ready low, in_ready is low and the
//   table holds; once the result is taken a new item may enter in that cycle.
`timescale 1ns / 1ps
`include "keyed_snapshot_table_mtf_defines.svh"

module keyed_snapshot_table_mtf import kstm_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               in_cmd,
  input  logic [KEY_W-1:0]         in_key,
  input  logic [MASK_W-1:0]        in_field_mask,
  input  logic signed [VAL_W-1:0]  in_write_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_ok,
  output logic signed [VAL_W-1:0]  out_read_value,
  output logic                     out_found,
  output logic [SLOT_W-1:0]        out_slot
);

  cell_ctl_t         ctl;
  record_t           rec    [TABLE_DEPTH];
  record_t           fresh_rec;
  cell_res_t         res    [TABLE_DEPTH];
  logic [TABLE_DEPTH:0]   hit_chain;
  logic [TABLE_DEPTH-1:0] sel_vec;
  logic              in_fire;
  logic              found_c;
  logic              ok_c;
  logic [VAL_W-1:0]  rval_c;
  logic [SLOT_W-1:0] slot_c;
  logic              cell_ok;

  logic              out_valid_r, out_valid_nxt;
  logic              ok_r;
  logic [VAL_W-1:0]  rval_r;
  logic              found_r;
  logic [SLOT_W-1:0] slot_r;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  assign ctl.accept = in_fire;
  assign ctl.cmd    = cmd_t'(in_cmd);
  assign ctl.key    = in_key;
  assign ctl.fmask  = in_field_mask;
  assign ctl.wval   = in_write_value;

  always_comb begin
    fresh_rec     = '0;
    fresh_rec.key = in_key;
  end

  assign hit_chain[0] = 1'b0;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    kstm_cell u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .ctl_i        (ctl),
      .cell_idx_i   (SLOT_W'(i)),
      .prev_rec_i   ((i == 0) ? fresh_rec : rec[(i == 0) ? 0 : i - 1]),
      .hit_before_i (hit_chain[i]),
      .hit_before_o (hit_chain[i+1]),
      .rec_o        (rec[i]),
      .res_o        (res[i])
    );
    assign sel_vec[i] = res[i].sel;
  end

  assign found_c = hit_chain[TABLE_DEPTH];

  always_comb begin
    cell_ok = 1'b0;
    rval_c  = '0;
    slot_c  = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      cell_ok = cell_ok | res[i].ok;
      rval_c  = rval_c | res[i].rval;
      slot_c  = slot_c | res[i].slot;
    end
    case (ctl.cmd)
      CMD_ALLOC:  ok_c = 1'b1;
      CMD_LOOKUP: ok_c = found_c;
      default:    ok_c = cell_ok;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      ok_r    <= ok_c;
      rval_r  <= rval_c;
      found_r <= found_c;
      slot_r  <= slot_c;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_ok         = ok_r;
  assign out_read_value = rval_r;
  assign out_found      = found_r;
  assign out_slot       = slot_r;

  `KSTM_ASSERT_SAME(a_one_sel, 1'b1, $onehot0(sel_vec), "more than one slot selected")
  `KSTM_ASSERT_SAME(a_found_sel, 1'b1, found_c == (sel_vec != '0), "found disagrees with select")
  `KSTM_ASSERT_NEXT(a_alloc_front, in_fire && (ctl.cmd == CMD_ALLOC), rec[0].key == $past(in_key), "allocate did not place key in front")
  `KSTM_ASSERT_SAME(a_ok_found, in_fire && ok_c && (ctl.cmd != CMD_ALLOC), found_c, "ok without a matching record")
  `KSTM_ASSERT_NEXT(a_result_valid, in_fire, out_valid_r, "accepted item produced no result")

endmodule

// ----- hdl/kstm_cell.sv -----
// one record slot of the move-to-front chain
`timescale 1ns / 1ps

module kstm_cell import kstm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  cell_ctl_t         ctl_i,
  input  logic [SLOT_W-1:0] cell_idx_i,
  input  record_t           prev_rec_i,
  input  logic              hit_before_i,
  output logic              hit_before_o,
  output record_t           rec_o,
  output cell_res_t         res_o
);

  record_t rec_r;
  record_t rec_nxt;
  logic    hit;
  logic    sel;

  assign hit          = (ctl_i.key != '0) && (rec_r.key == ctl_i.key);
  assign sel          = hit && !hit_before_i;
  assign hit_before_o = hit_before_i || hit;
  assign rec_o        = rec_r;

  always_comb begin
    rec_nxt    = rec_r;
    res_o      = '0;
    res_o.sel  = sel;
    res_o.slot = sel ? cell_idx_i : '0;
    case (ctl_i.cmd)
      CMD_ALLOC: begin
        // shift back unless the match sits in front of this slot
        if (!hit_before_i) begin
          rec_nxt = prev_rec_i;
        end
      end
      CMD_WRITE: begin
        if (sel && ((rec_r.mask & ctl_i.fmask) == '0)) begin
          rec_nxt.mask = rec_r.mask | ctl_i.fmask;
          case (ctl_i.fmask)
            MASK_VOLT: begin
              rec_nxt.volt = ctl_i.wval;
              res_o.ok     = 1'b1;
            end
            MASK_CURR: begin
              rec_nxt.curr = ctl_i.wval;
              res_o.ok     = 1'b1;
            end
            MASK_TEMP: begin
              rec_nxt.temp = ctl_i.wval;
              res_o.ok     = 1'b1;
            end
            default: ;
          endcase
        end
      end
      CMD_READ: begin
        if (sel && ((rec_r.mask & ctl_i.fmask) != '0)) begin
          case (ctl_i.fmask)
            MASK_VOLT: begin
              res_o.rval = rec_r.volt;
              res_o.ok   = 1'b1;
            end
            MASK_CURR: begin
              res_o.rval = rec_r.curr;
              res_o.ok   = 1'b1;
            end
            MASK_TEMP: begin
              res_o.rval = rec_r.temp;
              res_o.ok   = 1'b1;
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_r <= '0;
    end else if (ctl_i.accept) begin
      rec_r <= rec_nxt;
    end
  end

endmodule
